// ===== src/svpwm_pkg.sv =====
// Shared types and constants for the space vector PWM timing block.
// No dependencies; used by space_vector_pwm_timing.
package svpwm_pkg;

  // Period bits used out of the 16-bit period register
  localparam int unsigned PERIOD_BITS = 16;
  localparam int unsigned PeriodW     = (PERIOD_BITS < 16) ? PERIOD_BITS : 16;
  localparam logic [15:0] PeriodMask  = 16'((33'd1 << PeriodW) - 33'd1);

  // Q2.16 constant 1/sqrt3 (2/sqrt3 is twice this value)
  localparam logic signed [17:0] InvSqrt3Q16 = 18'sd37837;

  // Datapath widths
  localparam int unsigned TermW     = 33;               // alpha/beta terms, units 2^-31
  localparam int unsigned ProdW     = TermW + 17;       // term times period
  localparam int unsigned FracShift = 31;
  localparam int unsigned TimeW     = ProdW - FracShift; // active times in ticks
  localparam int unsigned DutyW     = 22;               // unclamped compare values

  // Configuration register indexes
  typedef enum logic {
    CfgPwmPeriod = 1'b0,
    CfgMaxMod    = 1'b1
  } cfg_idx_e;

  // Hexagon sectors
  typedef enum logic [2:0] {
    Sector1 = 3'd1,
    Sector2 = 3'd2,
    Sector3 = 3'd3,
    Sector4 = 3'd4,
    Sector5 = 3'd5,
    Sector6 = 3'd6
  } sector_e;

  typedef struct packed {
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
  } svpwm_in_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector_number;
  } svpwm_out_t;

endpackage

// ===== src/space_vector_pwm_timing.sv =====
// Space vector PWM timing: five-stage pipeline from (alpha, beta) to three
// clamped compare values and the sector. Depends on svpwm_pkg.

// Usage: each beat carries one alpha/beta vector (signed Q1.15) and yields one
// beat with the phase A/B/C compare values and the sector 1 to 6. The pipeline
// takes a new vector every cycle while in_stall_o is low, through five register
// stages (beta scaling, sector select, period multiply, truncation and half sum,
// ordering and clamp). in_stall_o rises only when all stages are full and the
// output is stalled. Write the timer period (register 0) and max_modulation
// (register 1) only while the pipeline is empty; the clamp limit is registered
// from those two registers.
module space_vector_pwm_timing (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  svpwm_pkg::svpwm_in_t  in_data_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output svpwm_pkg::svpwm_out_t out_data_o
);

  localparam int unsigned TermW     = svpwm_pkg::TermW;
  localparam int unsigned ProdW     = svpwm_pkg::ProdW;
  localparam int unsigned TimeW     = svpwm_pkg::TimeW;
  localparam int unsigned DutyW     = svpwm_pkg::DutyW;
  localparam int unsigned FracShift = svpwm_pkg::FracShift;

  // ---------------------------------------------------------------------------
  // Configuration registers and clamp limit
  // ---------------------------------------------------------------------------
  logic [15:0] timer_reload_q, max_mod_q;
  logic [15:0] tmax_q, tmax_d;
  logic [15:0] period;
  logic [33:0] tmax_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_reload_q <= 16'd4200;
      max_mod_q      <= 16'd62259;
    end else if (cfg_we_i) begin
      case (svpwm_pkg::cfg_idx_e'(cfg_idx_i))
        svpwm_pkg::CfgPwmPeriod: timer_reload_q <= cfg_wdata_i;
        svpwm_pkg::CfgMaxMod:    max_mod_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign period    = timer_reload_q & svpwm_pkg::PeriodMask;
  // t_max = P * (1 + max_mod) / 2, exact floor
  assign tmax_prod = 34'(period) * (34'd65536 + 34'(max_mod_q));
  assign tmax_d    = tmax_prod[32:17];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmax_q <= '0;
    end else begin
      tmax_q <= tmax_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or drains downstream
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5       = !s5_valid_q || !out_stall_i;
  assign adv4       = !s4_valid_q || adv5;
  assign adv3       = !s3_valid_q || adv4;
  assign adv2       = !s2_valid_q || adv3;
  assign adv1       = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
      if (adv3) s3_valid_q <= s2_valid_q;
      if (adv4) s4_valid_q <= s3_valid_q;
      if (adv5) s5_valid_q <= s4_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: beta / sqrt3 in units of 2^-31
  // ---------------------------------------------------------------------------
  logic signed [15:0] s1_alpha_q;
  logic signed [32:0] s1_b1_q, s1_b1_d;

  assign s1_b1_d = $signed({{17{in_data_i.v_beta[15]}}, in_data_i.v_beta})
                 * $signed({{15{1'b0}}, svpwm_pkg::InvSqrt3Q16});

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_alpha_q <= in_data_i.v_alpha;
      s1_b1_q    <= s1_b1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sector and the two active-vector terms
  // ---------------------------------------------------------------------------
  logic signed [TermW-1:0] a_t, b1_t, b2_t;
  logic                    beta_neg, alpha_neg;
  svpwm_pkg::sector_e      s2_sector_d, s2_sector_q;
  logic signed [TermW-1:0] s2_term_a_d, s2_term_b_d, s2_term_a_q, s2_term_b_q;

  assign a_t       = $signed({s1_alpha_q[15], s1_alpha_q, 16'd0});
  assign b1_t      = s1_b1_q;
  assign b2_t      = b1_t <<< 1;
  assign beta_neg  = b1_t[TermW-1];
  assign alpha_neg = s1_alpha_q[15];

  always_comb begin
    if (!beta_neg) begin
      if (!alpha_neg) s2_sector_d = (b1_t > a_t)  ? svpwm_pkg::Sector2 : svpwm_pkg::Sector1;
      else            s2_sector_d = (-b1_t > a_t) ? svpwm_pkg::Sector3 : svpwm_pkg::Sector2;
    end else begin
      if (!alpha_neg) s2_sector_d = (-b1_t > a_t) ? svpwm_pkg::Sector5 : svpwm_pkg::Sector6;
      else            s2_sector_d = (b1_t > a_t)  ? svpwm_pkg::Sector4 : svpwm_pkg::Sector5;
    end
  end

  always_comb begin
    case (s2_sector_d)
      svpwm_pkg::Sector1: begin
        s2_term_a_d = a_t - b1_t;
        s2_term_b_d = b2_t;
      end
      svpwm_pkg::Sector2: begin
        s2_term_a_d = a_t + b1_t;
        s2_term_b_d = b1_t - a_t;
      end
      svpwm_pkg::Sector3: begin
        s2_term_a_d = b2_t;
        s2_term_b_d = -a_t - b1_t;
      end
      svpwm_pkg::Sector4: begin
        s2_term_a_d = b1_t - a_t;
        s2_term_b_d = -b2_t;
      end
      svpwm_pkg::Sector5: begin
        s2_term_a_d = -a_t - b1_t;
        s2_term_b_d = a_t - b1_t;
      end
      default: begin
        s2_term_a_d = -b2_t;
        s2_term_b_d = a_t + b1_t;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      s2_sector_q <= s2_sector_d;
      s2_term_a_q <= s2_term_a_d;
      s2_term_b_q <= s2_term_b_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale both terms by the period
  // ---------------------------------------------------------------------------
  logic signed [ProdW-1:0] period_x, s3_prod_a_d, s3_prod_b_d, s3_prod_a_q, s3_prod_b_q;
  svpwm_pkg::sector_e      s3_sector_q;

  assign period_x    = $signed({{(ProdW-16){1'b0}}, period});
  assign s3_prod_a_d = $signed({{(ProdW-TermW){s2_term_a_q[TermW-1]}}, s2_term_a_q}) * period_x;
  assign s3_prod_b_d = $signed({{(ProdW-TermW){s2_term_b_q[TermW-1]}}, s2_term_b_q}) * period_x;

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_valid_q) begin
      s3_sector_q <= s2_sector_q;
      s3_prod_a_q <= s3_prod_a_d;
      s3_prod_b_q <= s3_prod_b_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: truncate toward zero, half sum truncated toward zero
  // ---------------------------------------------------------------------------
  localparam logic [ProdW-1:0] RoundBias = ProdW'((64'd1 << FracShift) - 64'd1);

  logic [ProdW-1:0]        biased_a, biased_b;
  logic signed [DutyW-1:0] ta_d, tb_d, sum_d, half_d;
  logic signed [DutyW-1:0] s4_ta_q, s4_tb_q, s4_half_q;
  svpwm_pkg::sector_e      s4_sector_q;

  assign biased_a = s3_prod_a_q + (s3_prod_a_q[ProdW-1] ? RoundBias : '0);
  assign biased_b = s3_prod_b_q + (s3_prod_b_q[ProdW-1] ? RoundBias : '0);
  assign ta_d     = $signed({{(DutyW-TimeW){biased_a[ProdW-1]}}, biased_a[ProdW-1:FracShift]});
  assign tb_d     = $signed({{(DutyW-TimeW){biased_b[ProdW-1]}}, biased_b[ProdW-1:FracShift]});
  assign sum_d    = $signed({{(DutyW-16){1'b0}}, period}) + ta_d + tb_d;
  assign half_d   = (sum_d + $signed({{(DutyW-1){1'b0}}, sum_d[DutyW-1]})) >>> 1;

  always_ff @(posedge clk_i) begin
    if (adv4 && s3_valid_q) begin
      s4_sector_q <= s3_sector_q;
      s4_ta_q     <= ta_d;
      s4_tb_q     <= tb_d;
      s4_half_q   <= half_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sector ordering, clamp, output register
  // ---------------------------------------------------------------------------
  logic signed [DutyW-1:0] da, db, dc;
  svpwm_pkg::svpwm_out_t   s5_data_q, s5_data_d;

  function automatic logic [15:0] clamp_duty(logic signed [DutyW-1:0] t, logic [15:0] tmax);
    logic [15:0] r;
    if (t[DutyW-1]) r = '0;
    else if (t > $signed({{(DutyW-16){1'b0}}, tmax})) r = tmax;
    else r = t[15:0];
    return r;
  endfunction

  always_comb begin
    case (s4_sector_q)
      svpwm_pkg::Sector1: begin
        da = s4_half_q;
        db = da - s4_ta_q;
        dc = db - s4_tb_q;
      end
      svpwm_pkg::Sector2: begin
        db = s4_half_q;
        da = db - s4_tb_q;
        dc = da - s4_ta_q;
      end
      svpwm_pkg::Sector3: begin
        db = s4_half_q;
        dc = db - s4_ta_q;
        da = dc - s4_tb_q;
      end
      svpwm_pkg::Sector4: begin
        dc = s4_half_q;
        db = dc - s4_tb_q;
        da = db - s4_ta_q;
      end
      svpwm_pkg::Sector5: begin
        dc = s4_half_q;
        da = dc - s4_ta_q;
        db = da - s4_tb_q;
      end
      default: begin
        da = s4_half_q;
        dc = da - s4_tb_q;
        db = dc - s4_ta_q;
      end
    endcase
  end

  assign s5_data_d.duty_a        = clamp_duty(da, tmax_q);
  assign s5_data_d.duty_b        = clamp_duty(db, tmax_q);
  assign s5_data_d.duty_c        = clamp_duty(dc, tmax_q);
  assign s5_data_d.sector_number = s4_sector_q;

  always_ff @(posedge clk_i) begin
    if (adv5 && s4_valid_q) begin
      s5_data_q <= s5_data_d;
    end
  end

  assign out_valid_o = s5_valid_q;
  assign out_data_o  = s5_data_q;

`ifndef SYNTHESIS
  // Input stalls only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && s3_valid_q && s4_valid_q
                    && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // Sector is always one of the six hexagon sectors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.sector_number != 3'd0 && out_data_o.sector_number != 3'd7))
    else $error("sector out of range");

  // Every duty respects the clamp limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.duty_a <= tmax_q && out_data_o.duty_b <= tmax_q
                     && out_data_o.duty_c <= tmax_q))
    else $error("duty above clamp limit");

  // In sector 1 both active times are non-negative: A >= B >= C
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.sector_number == svpwm_pkg::Sector1)
      |-> (out_data_o.duty_a >= out_data_o.duty_b && out_data_o.duty_b >= out_data_o.duty_c))
    else $error("sector 1 phase ordering broken");

  // Zero period gives all-zero duties
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && period == 16'd0)
      |-> (out_data_o.duty_a == 16'd0 && out_data_o.duty_b == 16'd0
           && out_data_o.duty_c == 16'd0))
    else $error("nonzero duty with zero period");
`endif

endmodule

// ===== dv/tb_space_vector_pwm_timing.sv =====
// Testbench for space_vector_pwm_timing: random and corner alpha/beta beats are
// checked against a duty/sector predictor under several period and limit settings.
// Depends on svpwm_pkg and the space_vector_pwm_timing RTL.
module tb_space_vector_pwm_timing;

  localparam int ClkHalf    = 6;
  localparam int RandPerSet = 100;
  localparam int NumSets    = 9;

  // Expected compare values and sectors, one entry per accepted vector
  class svpwm_duty_board;
    svpwm_pkg::svpwm_out_t duty_q[$];
    svpwm_pkg::svpwm_in_t  vec_q[$];
    logic [15:0]           period = 16'd4200;
    logic [15:0]           max_mod = 16'd62259;
    int                    errors = 0;

    function void set_config(logic [15:0] per, logic [15:0] mm);
      period  = per;
      max_mod = mm;
    endfunction

    function int pending();
      return duty_q.size();
    endfunction

    // Active times scaled by the period, truncated toward zero
    function longint scaled_time(longint term, longint p);
      return (term * p) / (64'sd1 <<< 31);
    endfunction

    function logic [15:0] clamp_duty(longint t, longint tmax);
      if (t < 0) t = 0;
      if (t > tmax) t = tmax;
      return t[15:0];
    endfunction

    function svpwm_pkg::svpwm_out_t compute_duties(svpwm_pkg::svpwm_in_t v);
      svpwm_pkg::svpwm_out_t r;
      svpwm_pkg::sector_e    sec;
      longint                al, be, a, b1, b2, p, ta, tb, da, db, dc, tmax;
      al = $signed(v.v_alpha);
      be = $signed(v.v_beta);
      a  = al * 65536;
      b1 = be * 37837;
      b2 = be * 75674;
      p  = {48'd0, period & svpwm_pkg::PeriodMask};

      // zero on an axis counts as non-negative
      if (be >= 0) begin
        if (al >= 0) sec = (b1 > a) ? svpwm_pkg::Sector2 : svpwm_pkg::Sector1;
        else sec = (-b1 > a) ? svpwm_pkg::Sector3 : svpwm_pkg::Sector2;
      end else begin
        if (al >= 0) sec = (-b1 > a) ? svpwm_pkg::Sector5 : svpwm_pkg::Sector6;
        else sec = (b1 > a) ? svpwm_pkg::Sector4 : svpwm_pkg::Sector5;
      end

      case (sec)
        svpwm_pkg::Sector1: begin
          ta = scaled_time(a - b1, p);
          tb = scaled_time(b2, p);
          da = (p + ta + tb) / 2;
          db = da - ta;
          dc = db - tb;
        end
        svpwm_pkg::Sector2: begin
          ta = scaled_time(a + b1, p);
          tb = scaled_time(-a + b1, p);
          db = (p + ta + tb) / 2;
          da = db - tb;
          dc = da - ta;
        end
        svpwm_pkg::Sector3: begin
          ta = scaled_time(b2, p);
          tb = scaled_time(-a - b1, p);
          db = (p + ta + tb) / 2;
          dc = db - ta;
          da = dc - tb;
        end
        svpwm_pkg::Sector4: begin
          ta = scaled_time(-a + b1, p);
          tb = scaled_time(-b2, p);
          dc = (p + ta + tb) / 2;
          db = dc - tb;
          da = db - ta;
        end
        svpwm_pkg::Sector5: begin
          ta = scaled_time(-a - b1, p);
          tb = scaled_time(a - b1, p);
          dc = (p + ta + tb) / 2;
          da = dc - ta;
          db = da - tb;
        end
        default: begin
          ta = scaled_time(-b2, p);
          tb = scaled_time(a + b1, p);
          da = (p + ta + tb) / 2;
          dc = da - tb;
          db = dc - ta;
        end
      endcase

      tmax = (p * (65536 + longint'({48'd0, max_mod}))) >>> 17;
      r.duty_a        = clamp_duty(da, tmax);
      r.duty_b        = clamp_duty(db, tmax);
      r.duty_c        = clamp_duty(dc, tmax);
      r.sector_number = sec;
      return r;
    endfunction

    function void note_input(svpwm_pkg::svpwm_in_t v);
      duty_q.push_back(compute_duties(v));
      vec_q.push_back(v);
    endfunction

    // One line per mismatch
    task report(string msg);
      errors++;
      $display("mismatch @%0t: %s", $time, msg);
    endtask

    task check_result(svpwm_pkg::svpwm_out_t got);
      svpwm_pkg::svpwm_out_t want;
      svpwm_pkg::svpwm_in_t  src;
      string                 tag;
      if (duty_q.size() == 0) begin
        report("output beat with no vector pending");
        return;
      end
      want = duty_q.pop_front();
      src  = vec_q.pop_front();
      tag  = $sformatf("alpha %0d beta %0d period %0d maxmod %0d",
                       src.v_alpha, src.v_beta, period, max_mod);
      if (got.duty_a !== want.duty_a)
        report($sformatf("duty_a %0d want %0d, %s", got.duty_a, want.duty_a, tag));
      if (got.duty_b !== want.duty_b)
        report($sformatf("duty_b %0d want %0d, %s", got.duty_b, want.duty_b, tag));
      if (got.duty_c !== want.duty_c)
        report($sformatf("duty_c %0d want %0d, %s", got.duty_c, want.duty_c, tag));
      if (got.sector_number !== want.sector_number)
        report($sformatf("sector %0d want %0d, %s", got.sector_number,
                         want.sector_number, tag));
    endtask

    task flush_check();
      if (duty_q.size() != 0)
        report($sformatf("%0d expected beats never came out", duty_q.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  svpwm_pkg::cfg_idx_e   cfg_idx;
  logic [15:0]           cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  svpwm_pkg::svpwm_in_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  svpwm_pkg::svpwm_out_t out_data;

  svpwm_duty_board sb = new();

  int in_burst  = 0;
  int out_burst = 0;

  space_vector_pwm_timing dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Idle length: mostly none or short, a few long, with stretches of none
  function automatic int pick_gap(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random vector: full range, inside the hexagon, near sector edges, corners
  function automatic svpwm_pkg::svpwm_in_t random_vector();
    svpwm_pkg::svpwm_in_t v;
    int                   corners[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    int                   mode, al, mag;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: begin
        v.v_alpha = 16'($urandom());
        v.v_beta  = 16'($urandom());
      end
      3, 4, 5: begin
        v.v_alpha = 16'($urandom_range(0, 37836) - 18918);
        v.v_beta  = 16'($urandom_range(0, 37836) - 18918);
      end
      6: begin
        // beta close to +-sqrt3 * alpha
        al  = $urandom_range(0, 18000);
        mag = (al * 56756) / 32768 + $urandom_range(0, 6) - 3;
        if ($urandom_range(0, 1)) al = -al;
        if ($urandom_range(0, 1)) mag = -mag;
        v.v_alpha = 16'(al);
        v.v_beta  = 16'(mag);
      end
      7: begin
        v.v_alpha = 16'(corners[$urandom_range(0, 6)]);
        v.v_beta  = 16'(corners[$urandom_range(0, 6)]);
      end
      default: begin
        v.v_alpha = 16'($urandom_range(0, 52000) - 26000);
        v.v_beta  = 16'($urandom_range(0, 52000) - 26000);
      end
    endcase
    return v;
  endfunction

  // Send one input beat; entered and left at a falling edge
  task automatic send_vector(logic signed [15:0] al, logic signed [15:0] be);
    int                   gap;
    svpwm_pkg::svpwm_in_t v;
    v.v_alpha = al;
    v.v_beta  = be;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
    sb.note_input(v);
    @(negedge clk);
  endtask

  // Drop valid and wait for the pipeline to empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write both registers while idle
  task automatic write_config(logic [15:0] per, logic [15:0] mm);
    cfg_we    <= 1'b1;
    cfg_idx   <= svpwm_pkg::CfgPwmPeriod;
    cfg_wdata <= per;
    @(negedge clk);
    cfg_idx   <= svpwm_pkg::CfgMaxMod;
    cfg_wdata <= mm;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_config(per, mm);
    // clamp limit is registered from the written values
    repeat (3) @(negedge clk);
  endtask

  // Output stall pattern
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = pick_gap(out_burst);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  end

  // Output beat monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_data);
  end

  // Main sequence
  initial begin
    int                   dir_a[21] = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768,
                                        -1, 0, -1, 10000, 10000, -10000, -10000,
                                        10000, 10000, -10000, -10000, 16384};
    int                   dir_b[21] = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767,
                                        0, -1, -1, 17320, 17321, 17320, 17321,
                                        -17320, -17321, -17320, -17321, 9459};
    logic [15:0]          per, mm;
    svpwm_pkg::svpwm_in_t v;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = svpwm_pkg::CfgPwmPeriod;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Corners, axes and sector edges at the reset setting
    for (int i = 0; i < 21; i++)
      send_vector(16'(dir_a[i]), 16'(dir_b[i]));

    for (int s = 0; s < NumSets; s++) begin
      if (s > 0) begin
        case (s)
          1: begin per = 16'hFFFF; mm = 16'hFFFF; end
          2: begin per = 16'd0;    mm = 16'd0;    end  // zero period
          3: begin per = 16'd1;    mm = 16'd0;    end
          4: begin per = 16'hFFFF; mm = 16'd0;    end
          5: begin per = 16'd1;    mm = 16'hFFFF; end
          6: begin per = 16'($urandom()); mm = 16'($urandom()); end
          7: begin per = 16'($urandom_range(2, 255)); mm = 16'($urandom()); end
          default: begin per = 16'd4200; mm = 16'd62259; end
        endcase
        wait_idle();
        write_config(per, mm);
      end
      for (int i = 0; i < RandPerSet; i++) begin
        v = random_vector();
        send_vector(v.v_alpha, v.v_beta);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    sb.flush_check();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * ClkHalf * 600000);
    $display("FAILURE");
    $finish;
  end

endmodule
